FILE: rtl/nvm_pkg.sv
// ----------------------------------------------------------------------------
// nvm_pkg
// Shared types and constants of the nearest value matcher: payload structs,
// cell links, control bundles and the sequencer states.
// ----------------------------------------------------------------------------
package nvm_pkg;

	localparam int POOL_DEPTH  = 1024;
	localparam int VALUE_W     = 31;
	localparam int TOTAL_W     = 20;
	localparam int GRP_SIZE    = 32;
	localparam int GRP_COUNT   = (POOL_DEPTH + GRP_SIZE - 1) / GRP_SIZE;
	localparam int PAD_DEPTH   = GRP_COUNT * GRP_SIZE;
	localparam int RECIP_W     = 32;
	localparam int PROD_W      = VALUE_W + RECIP_W;
	localparam int RECIP_SHIFT = 51;
	localparam int QUOT_W      = 12;
	localparam int RQ_W        = QUOT_W + TOTAL_W;

	localparam logic [TOTAL_W-1:0] TOTAL_MOD = 20'd1000000;
	// ceil(2**51 / 1000000), exact quotient for any 31-bit cost
	localparam logic [RECIP_W-1:0] RECIP     = 32'd2251799814;

	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [TOTAL_W-1:0] total_t;

	typedef struct packed {
		logic   kind;
		value_t value;
	} arrival_t;

	typedef struct packed {
		logic   matched;
		value_t partner_value;
		value_t match_cost;
		total_t total_cost;
		logic   overflow;
	} result_t;

	typedef struct packed {
		logic   occ;
		logic   le;
		logic   ge;
		value_t value;
	} cell_link_t;

	typedef struct packed {
		logic scan;
		logic upd;
		logic insert;
		logic remove;
		logic pick_pre;
	} chain_ctrl_t;

	typedef struct packed {
		logic   empty;
		logic   full;
		logic   has_pre;
		logic   has_nxt;
		value_t pred;
		value_t succ;
	} chain_stat_t;

	typedef struct packed {
		logic mul;
		logic mq;
		logic add;
	} acc_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RED1,
		ST_RED2,
		ST_DEC,
		ST_UPD,
		ST_MUL,
		ST_RES
	} state_t;

endpackage

FILE: rtl/nearest_value_matcher.sv
// ----------------------------------------------------------------------------
// nearest_value_matcher
// Keeps a sorted pool of one side's values and pairs each arrival of the
// other side with its nearest pooled value, tracking the total cost.
// ----------------------------------------------------------------------------
// The pool is a chain of 1024 cells that stays in ascending order; an
// arrival is broadcast to every cell at once, so pool size does not change
// timing. Each arrival passes through the transfer, a compare in the cells,
// the registered OR tree that pulls out the neighbors of the value, a
// decision, the shift of the chain to insert or remove, which also starts the
// reciprocal multiply, and the back multiply of the modulo reduction before
// the result register is loaded. One arrival is in flight at a time; the next
// transfer is taken in the cycle after the result is loaded, even while that
// result still waits to be taken. A store into a full pool is dropped and
// flagged with overflow. The pool needs no clearing after reset.
// ----------------------------------------------------------------------------
module nearest_value_matcher (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              arrival_valid,
	output logic              arrival_ready,
	input  nvm_pkg::arrival_t arrival,
	output logic              result_valid,
	input  logic              result_ready,
	output nvm_pkg::result_t  result
);
	import nvm_pkg::*;

	state_t      state_q;
	state_t      state_d;
	arrival_t    arr_q;
	logic        pool_kind_q;
	logic        is_match_q;
	logic        matched_q;
	logic        overflow_q;
	logic        pick_pre_q;
	value_t      partner_q;
	value_t      cost_q;
	result_t     result_q;
	logic        result_valid_q;
	logic        go;
	logic        pick_pre;
	value_t      dist_pre;
	value_t      dist_nxt;
	chain_ctrl_t chain_ctrl;
	chain_stat_t stat;
	acc_ctrl_t   acc_ctrl;
	total_t      total_next;

	assign go       = ~result_valid_q | result_ready;
	assign dist_pre = arr_q.value - stat.pred;
	assign dist_nxt = stat.succ - arr_q.value;
	assign pick_pre = stat.has_pre & (~stat.has_nxt | (dist_pre <= dist_nxt));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (arrival_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: state_d = ST_RED1;
			ST_RED1: state_d = ST_RED2;
			ST_RED2: state_d = ST_DEC;
			ST_DEC:  state_d = ST_UPD;
			ST_UPD:  state_d = ST_MUL;
			ST_MUL:  state_d = ST_RES;
			ST_RES: begin
				if (go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		arrival_ready       = 1'b0;
		chain_ctrl          = '0;
		chain_ctrl.pick_pre = pick_pre_q;
		chain_ctrl.remove   = is_match_q;
		chain_ctrl.insert   = ~is_match_q & ~overflow_q;
		acc_ctrl            = '0;
		unique case (state_q)
			ST_IDLE: arrival_ready   = 1'b1;
			ST_SCAN: chain_ctrl.scan = 1'b1;
			ST_UPD: begin
				chain_ctrl.upd = 1'b1;
				acc_ctrl.mul   = 1'b1;
			end
			ST_MUL:  acc_ctrl.mq  = 1'b1;
			ST_RES:  acc_ctrl.add = go;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			pool_kind_q    <= 1'b0;
			is_match_q     <= 1'b0;
			matched_q      <= 1'b0;
			overflow_q     <= 1'b0;
			pick_pre_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && arrival_valid) begin
				if (stat.empty) begin
					pool_kind_q <= arrival.kind;
				end
				is_match_q <= ~stat.empty & (arrival.kind != pool_kind_q);
			end
			if (state_q == ST_DEC) begin
				matched_q  <= is_match_q;
				overflow_q <= ~is_match_q & stat.full;
				pick_pre_q <= pick_pre;
			end
			if (state_q == ST_RES && go) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && arrival_valid) begin
			arr_q <= arrival;
		end
		if (state_q == ST_DEC) begin
			if (!is_match_q) begin
				partner_q <= '0;
				cost_q    <= '0;
			end else if (pick_pre) begin
				partner_q <= stat.pred;
				cost_q    <= dist_pre;
			end else begin
				partner_q <= stat.succ;
				cost_q    <= dist_nxt;
			end
		end
		if (state_q == ST_RES && go) begin
			result_q.matched       <= matched_q;
			result_q.partner_value <= partner_q;
			result_q.match_cost    <= cost_q;
			result_q.total_cost    <= total_next;
			result_q.overflow      <= overflow_q;
		end
	end

	nvm_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (arr_q.value),
		.ctrl   (chain_ctrl),
		.stat   (stat)
	);

	nvm_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (acc_ctrl),
		.cost       (cost_q),
		.total_next (total_next)
	);

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_match_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> !(result_q.matched && result_q.overflow))
		else $error("result both matched and overflowed");
	a_store_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && !result_q.matched) |->
		(result_q.partner_value == '0 && result_q.match_cost == '0))
		else $error("stored arrival reports a partner or cost");
	a_update_no_drop_on_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD && is_match_q) |-> !overflow_q && chain_ctrl.remove)
		else $error("match flagged as dropped store");
	a_transfer_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(arrival_valid && arrival_ready) |=> state_q == ST_SCAN)
		else $error("transfer did not start a pool scan");
`endif

endmodule

FILE: rtl/nvm_cell.sv
// ----------------------------------------------------------------------------
// nvm_cell
// One slot of the sorted pool: holds a value and its occupancy, compares
// against the broadcast key and shifts left or right with its neighbors.
// ----------------------------------------------------------------------------
module nvm_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  nvm_pkg::value_t     key,
	input  nvm_pkg::chain_ctrl_t ctrl,
	input  nvm_pkg::cell_link_t prv,
	input  nvm_pkg::cell_link_t nxt,
	output nvm_pkg::cell_link_t link,
	output logic                pred_sel,
	output logic                succ_sel
);
	import nvm_pkg::*;

	logic   occ_q;
	logic   le_q;
	logic   ge_q;
	value_t value_q;
	logic   le_d;
	logic   ge_d;
	logic   rm_shift;
	logic   ins_here;
	logic   ins_shift;

	assign le_d      = occ_q & (value_q <= key);
	assign ge_d      = occ_q & (value_q >= key);
	// at or after the removed slot
	assign rm_shift  = ctrl.pick_pre ? ~nxt.le : (ge_q | ~occ_q);
	assign ins_here  = ~le_q & prv.le;
	assign ins_shift = ~le_q & ~prv.le;

	assign pred_sel = le_q & ~nxt.le;
	assign succ_sel = ge_q & ~prv.ge;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
			le_q  <= 1'b0;
			ge_q  <= 1'b0;
		end else begin
			if (ctrl.scan) begin
				le_q <= le_d;
				ge_q <= ge_d;
			end
			if (ctrl.upd && ctrl.remove && rm_shift) begin
				occ_q <= nxt.occ;
			end else if (ctrl.upd && ctrl.insert && ins_here) begin
				occ_q <= 1'b1;
			end else if (ctrl.upd && ctrl.insert && ins_shift) begin
				occ_q <= prv.occ;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.upd && ctrl.remove && rm_shift) begin
			value_q <= nxt.value;
		end else if (ctrl.upd && ctrl.insert && ins_here) begin
			value_q <= key;
		end else if (ctrl.upd && ctrl.insert && ins_shift) begin
			value_q <= prv.value;
		end
	end

	assign link = '{occ: occ_q, le: le_q, ge: ge_q, value: value_q};

endmodule

FILE: rtl/nvm_chain.sv
// ----------------------------------------------------------------------------
// nvm_chain
// Row of pool cells kept in ascending order, with a two-level registered
// OR tree that picks out the predecessor and successor of the key.
// ----------------------------------------------------------------------------
module nvm_chain (
	input  logic                 clk,
	input  logic                 arst_n,
	input  nvm_pkg::value_t      key,
	input  nvm_pkg::chain_ctrl_t ctrl,
	output nvm_pkg::chain_stat_t stat
);
	import nvm_pkg::*;

	localparam cell_link_t HEAD_LINK = '{occ: 1'b1, le: 1'b1, ge: 1'b0, value: '0};

	cell_link_t              link [POOL_DEPTH];
	logic [POOL_DEPTH-1:0]   occ_vec;
	logic [POOL_DEPTH-1:0]   pred_sel;
	logic [POOL_DEPTH-1:0]   succ_sel;
	value_t                  pred_pad [PAD_DEPTH];
	value_t                  succ_pad [PAD_DEPTH];
	logic [PAD_DEPTH-1:0]    ge_pad;
	value_t                  grp_pred_d [GRP_COUNT];
	value_t                  grp_succ_d [GRP_COUNT];
	logic [GRP_COUNT-1:0]    grp_ge_d;
	value_t                  grp_pred_s1 [GRP_COUNT];
	value_t                  grp_succ_s1 [GRP_COUNT];
	logic [GRP_COUNT-1:0]    grp_ge_s1;
	value_t                  pred_d;
	value_t                  succ_d;
	value_t                  pred_s2;
	value_t                  succ_s2;
	logic                    has_nxt_s2;

	for (genvar i = 0; i < POOL_DEPTH; i++) begin : g_cell
		cell_link_t prv;
		cell_link_t nxt;
		if (i == 0) begin : g_head
			assign prv = HEAD_LINK;
		end else begin : g_body
			assign prv = link[i-1];
		end
		if (i == POOL_DEPTH - 1) begin : g_tail
			assign nxt = '0;
		end else begin : g_next
			assign nxt = link[i+1];
		end

		nvm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.key      (key),
			.ctrl     (ctrl),
			.prv      (prv),
			.nxt      (nxt),
			.link     (link[i]),
			.pred_sel (pred_sel[i]),
			.succ_sel (succ_sel[i])
		);

		assign occ_vec[i]  = link[i].occ;
		assign pred_pad[i] = pred_sel[i] ? link[i].value : '0;
		assign succ_pad[i] = succ_sel[i] ? link[i].value : '0;
		assign ge_pad[i]   = link[i].ge;
	end

	for (genvar i = POOL_DEPTH; i < PAD_DEPTH; i++) begin : g_pad
		assign pred_pad[i] = '0;
		assign succ_pad[i] = '0;
		assign ge_pad[i]   = 1'b0;
	end

	// first level: one OR per group of cells
	always_comb begin
		for (int g = 0; g < GRP_COUNT; g++) begin
			grp_pred_d[g] = '0;
			grp_succ_d[g] = '0;
			grp_ge_d[g]   = 1'b0;
			for (int j = 0; j < GRP_SIZE; j++) begin
				grp_pred_d[g] = grp_pred_d[g] | pred_pad[g*GRP_SIZE + j];
				grp_succ_d[g] = grp_succ_d[g] | succ_pad[g*GRP_SIZE + j];
				grp_ge_d[g]   = grp_ge_d[g] | ge_pad[g*GRP_SIZE + j];
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_pred_s1 <= grp_pred_d;
		grp_succ_s1 <= grp_succ_d;
		grp_ge_s1   <= grp_ge_d;
	end

	// second level: across the groups
	always_comb begin
		pred_d = '0;
		succ_d = '0;
		for (int g = 0; g < GRP_COUNT; g++) begin
			pred_d = pred_d | grp_pred_s1[g];
			succ_d = succ_d | grp_succ_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		pred_s2    <= pred_d;
		succ_s2    <= succ_d;
		has_nxt_s2 <= |grp_ge_s1;
	end

	assign stat.empty   = ~occ_vec[0];
	assign stat.full    = occ_vec[POOL_DEPTH-1];
	assign stat.has_pre = link[0].le;
	assign stat.has_nxt = has_nxt_s2;
	assign stat.pred    = pred_s2;
	assign stat.succ    = succ_s2;

`ifndef SYNTHESIS
	a_occ_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_vec & (occ_vec + 1'b1)) == '0)
		else $error("pool occupancy has a hole");
	a_pred_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(pred_sel))
		else $error("more than one predecessor cell selected");
	a_succ_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(succ_sel))
		else $error("more than one successor cell selected");
`endif

endmodule

FILE: rtl/nvm_accum.sv
// ----------------------------------------------------------------------------
// nvm_accum
// Running total of match costs modulo one million: cost is reduced through
// a reciprocal multiply and a back multiply, then added with one wrap.
// ----------------------------------------------------------------------------
module nvm_accum (
	input  logic               clk,
	input  logic               arst_n,
	input  nvm_pkg::acc_ctrl_t ctrl,
	input  nvm_pkg::value_t    cost,
	output nvm_pkg::total_t    total_next
);
	import nvm_pkg::*;

	logic [PROD_W-1:0] prod_s1;
	logic [RQ_W-1:0]   rq_s2;
	logic [QUOT_W-1:0] quot;
	total_t            rem;
	logic [TOTAL_W:0]  sum;
	total_t            total_q;

	assign quot = prod_s1[RECIP_SHIFT +: QUOT_W];
	assign rem  = cost[TOTAL_W-1:0] - rq_s2[TOTAL_W-1:0];
	assign sum  = {1'b0, total_q} + {1'b0, rem};

	always_comb begin
		if (sum >= {1'b0, TOTAL_MOD}) begin
			total_next = TOTAL_W'(sum - {1'b0, TOTAL_MOD});
		end else begin
			total_next = sum[TOTAL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			prod_s1 <= PROD_W'(cost) * PROD_W'(RECIP);
		end
		if (ctrl.mq) begin
			rq_s2 <= RQ_W'(quot) * RQ_W'(TOTAL_MOD);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (ctrl.add) begin
			total_q <= total_next;
		end
	end

endmodule

FILE: tb/nearest_value_matcher_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_value_matcher_test
// Self-checking testbench for the nearest value matcher. Directed arrivals
// cover value extremes, ties, equal and duplicate values and a pool emptied
// by a match. Random bursts of same-side arrivals follow. Both ports idle
// and stall at random, and each result is compared against a behavioral
// model of the sorted pool.
// ----------------------------------------------------------------------------
module nearest_value_matcher_test;
	import nvm_pkg::*;

	localparam int     CYCLE_LIMIT  = 800000;
	localparam int     RANDOM_ITEMS = 380;
	localparam int     SETTLE_TIME  = 40;
	localparam value_t VALUE_MAX    = '1;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     arrival_valid;
	logic     arrival_ready;
	arrival_t arrival;
	logic     result_valid;
	logic     result_ready;
	result_t  result;

	// model state
	value_t   held_values[$];
	logic     held_kind;
	total_t   cost_sum;
	result_t  pending_results[$];

	bit       steady;
	int       mismatches;
	int       cycle_count;

	nearest_value_matcher i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.arrival_valid(arrival_valid),
		.arrival_ready(arrival_ready),
		.arrival      (arrival),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic value_t rand_value();
		return value_t'($urandom);
	endfunction

	// mostly short idle stretches, a few long ones
	function automatic int idle_len();
		if ($urandom_range(0, 9) < 7)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	// pairs an arrival with the nearest held value or stores it in order
	function automatic result_t match_arrival(arrival_t a);
		result_t r;
		int      lo;
		int      up;
		int      pick;
		value_t  cost;
		r = '0;
		lo = 0;
		while (lo < held_values.size() && held_values[lo] < a.value)
			lo++;
		up = lo;
		while (up < held_values.size() && held_values[up] <= a.value)
			up++;
		if (held_values.size() == 0 || a.kind == held_kind) begin
			if (held_values.size() == 0)
				held_kind = a.kind;
			if (held_values.size() >= POOL_DEPTH)
				r.overflow = 1'b1;
			else
				held_values.insert(up, a.value);
		end else begin
			if (up > 0 && (lo == held_values.size() ||
			    (a.value - held_values[up-1]) <= (held_values[lo] - a.value))) begin
				pick = up - 1;
				cost = a.value - held_values[pick];
			end else begin
				pick = lo;
				cost = held_values[pick] - a.value;
			end
			r.matched       = 1'b1;
			r.partner_value = held_values[pick];
			r.match_cost    = cost;
			held_values.delete(pick);
			cost_sum = total_t'((longint'(cost_sum) + longint'(cost)) % longint'(TOTAL_MOD));
		end
		r.total_cost = cost_sum;
		return r;
	endfunction

	task automatic send_arrival(logic kind, value_t value);
		int gap;
		gap = (!steady && $urandom_range(0, 2) == 0) ? idle_len() : 0;
		if (gap > 0) begin
			arrival_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		arrival       <= '{kind: kind, value: value};
		arrival_valid <= 1'b1;
		do
			@(posedge clk);
		while (!arrival_ready);
		pending_results.push_back(match_arrival('{kind: kind, value: value}));
	endtask

	task automatic compare_field(string field, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %p", $time, result);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				compare_field("matched", want.matched, result.matched);
				compare_field("partner_value", want.partner_value, result.partner_value);
				compare_field("match_cost", want.match_cost, result.match_cost);
				compare_field("total_cost", want.total_cost, result.total_cost);
				compare_field("overflow", want.overflow, result.overflow);
			end
		end
	end

	initial begin
		int n;
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!steady && $urandom_range(0, 3) == 0) begin
				n = idle_len();
				result_ready <= 1'b0;
				repeat (n - 1) @(posedge clk);
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// largest costs, wrap of the running total, pool emptied by a match
	task automatic test_extremes();
		send_arrival(1'b1, VALUE_MAX);
		send_arrival(1'b0, '0);
		send_arrival(1'b1, '0);
		send_arrival(1'b0, VALUE_MAX);
		send_arrival(1'b0, value_t'(31'h5555_5555));
		send_arrival(1'b1, value_t'(31'h2AAA_AAAA));
		send_arrival(1'b1, VALUE_MAX);
		send_arrival(1'b0, VALUE_MAX);
	endtask

	// ties go to the smaller value, equal values match at zero cost
	task automatic test_ties_and_duplicates();
		send_arrival(1'b0, value_t'(100));
		send_arrival(1'b0, value_t'(200));
		send_arrival(1'b0, value_t'(300));
		send_arrival(1'b0, value_t'(200));
		send_arrival(1'b1, value_t'(150));
		send_arrival(1'b1, value_t'(200));
		send_arrival(1'b1, value_t'(250));
		send_arrival(1'b1, value_t'(1000));
		send_arrival(1'b1, value_t'(5));
		send_arrival(1'b0, value_t'(3));
		send_arrival(1'b0, value_t'(7));
		send_arrival(1'b1, value_t'(7));
		send_arrival(1'b1, value_t'(7));
		send_arrival(1'b0, value_t'(9));
	endtask

	// bursts of one side around a moving base keep the pool shallow and busy
	task automatic test_random_traffic();
		int     sent;
		int     burst;
		logic   side;
		value_t base;
		value_t v;
		sent = 0;
		base = rand_value();
		while (sent < RANDOM_ITEMS) begin
			steady = ($urandom_range(0, 4) == 0);
			side   = 1'($urandom_range(0, 1));
			burst  = $urandom_range(1, 6);
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 3))
					0: base = '0;
					1: base = VALUE_MAX - value_t'(63);
					default: base = rand_value();
				endcase
			end
			repeat (burst) begin
				v = ($urandom_range(0, 3) == 0) ? rand_value()
				                                : value_t'(base + $urandom_range(0, 63));
				send_arrival(side, v);
				sent++;
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n        <= 1'b0;
		arrival_valid <= 1'b0;
		arrival       <= '0;
		held_kind     = 1'b0;
		cost_sum      = '0;
		steady        = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_ties_and_duplicates();
		test_random_traffic();

		arrival_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TIME) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
